/* rtl/core/dsfe_pkg.sv */
`default_nettype none

package dsfe_pkg;

   // framing codes
   localparam logic [7:0] DLE_CODE = 8'h10;
   localparam logic [7:0] STX_CODE = 8'h02;
   localparam logic [7:0] ETX_CODE = 8'h03;
   // length byte carries the payload count plus this bias
   localparam logic [7:0] LEN_BIAS = 8'h02;

   // one classified payload byte, handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] len_byte;
      logic [7:0] csum;
      logic       first;
      logic       last;
   } cmd_type;

   // line byte being produced by the back sequencer
   typedef enum logic [9:0] {
      PH_HDR_DLE  = 10'b0000000001,
      PH_HDR_STX  = 10'b0000000010,
      PH_LEN      = 10'b0000000100,
      PH_LEN_DUP  = 10'b0000001000,
      PH_DATA     = 10'b0000010000,
      PH_DATA_DUP = 10'b0000100000,
      PH_SUM      = 10'b0001000000,
      PH_SUM_DUP  = 10'b0010000000,
      PH_TRL_DLE  = 10'b0100000000,
      PH_TRL_ETX  = 10'b1000000000
   } phase_type;

endpackage

`default_nettype wire

/* rtl/core/dsfe_req_if.sv */
`default_nettype none

interface dsfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       first_byte;
   logic       last_byte;
   logic [7:0] payload_length;

   modport source (output valid, payload_byte, first_byte, last_byte, payload_length,
                   input ready);
   modport sink (input valid, payload_byte, first_byte, last_byte, payload_length,
                 output ready);
endinterface

`default_nettype wire

/* rtl/core/dsfe_rsp_if.sv */
`default_nettype none

interface dsfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, frame_byte, run_last, frame_end, input ready);
   modport sink (input valid, frame_byte, run_last, frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/dle_stuffed_frame_encoder_unit.sv */
// DLE framing encoder: payload bytes come in on req_ch with first/last marks and
// the message length; stuffed line bytes leave on rsp_ch, one per cycle while
// rsp_ch is ready. A first byte opens the frame with DLE, STX and a length byte
// (length + 2), every 0x10 in length, payload or checksum is sent twice, and a
// last byte closes the frame with the 8-bit additive checksum, DLE and ETX (ETX
// flagged by frame_end, and run_last marks the final line byte of each request).
// One request expands to 1 to 10 line bytes, which the back sequencer sends in
// turn while it holds the request; the front takes a new request every cycle
// while the QUEUE_DEPTH entry queue has room, so with rsp_ch ready plain payload
// bytes stream at one per cycle and a doubled 0x10 adds one more line byte.
`default_nettype none

module dle_stuffed_frame_encoder_unit
   import dsfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic       clock,
   input  logic       reset,
   dsfe_req_if.sink   req_ch,
   dsfe_rsp_if.source rsp_ch
);

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // accept and checksum
   dsfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // decoupling queue
   dsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .cmd_in     (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head_cmd)
   );

   // line byte sequencer
   dsfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

/* rtl/core/dsfe_front.sv */
`default_nettype none

module dsfe_front
   import dsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dsfe_req_if.sink   req_ch,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    cmd
);

   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [7:0] sum_base;
   logic [7:0] sum_new;

   // take a request whenever the queue has room
   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && req_ch.ready;

   // checksum restarts on a first byte
   assign sum_base = req_ch.first_byte ? 8'h00 : sum_ff;
   assign sum_new  = sum_base + req_ch.payload_byte;

   // classified request for the back end
   always_comb begin
      cmd.data     = req_ch.payload_byte;
      cmd.len_byte = req_ch.payload_length + LEN_BIAS;
      cmd.csum     = sum_new;
      cmd.first    = req_ch.first_byte;
      cmd.last     = req_ch.last_byte;
   end

   // running sum, cleared after a closing byte
   always_comb begin
      sum_in = sum_ff;
      if (push) begin
         sum_in = req_ch.last_byte ? 8'h00 : sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= 8'h00;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dsfe_queue.sv */
`default_nettype none

module dsfe_queue
   import dsfe_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type             slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff;
   logic [PtrW-1:0]     wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff;
   logic [PtrW-1:0]     rd_ptr_in;
   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dsfe_back.sv */
`default_nettype none

module dsfe_back
   import dsfe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      pop,
   dsfe_rsp_if.source rsp_ch
);

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] frame_byte_ff;
   logic       run_last_ff;
   logic       frame_end_ff;
   phase_type  phase_ff;
   phase_type  phase_in;
   logic       busy_ff;
   logic       busy_in;

   phase_type  cur_phase;
   phase_type  next_phase;
   logic [7:0] line_byte;
   logic       done;
   logic       load;

   // output register frees up when empty or taken
   assign load = cmd_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop  = load && done;

   // entry point of a fresh request
   assign cur_phase = busy_ff ? phase_ff : (cmd.first ? PH_HDR_DLE : PH_DATA);

   // byte select and step to the next line byte
   always_comb begin
      line_byte  = DLE_CODE;
      next_phase = PH_DATA;
      done       = 1'b0;
      unique case (cur_phase)
         PH_HDR_DLE: begin
            line_byte  = DLE_CODE;
            next_phase = PH_HDR_STX;
         end
         PH_HDR_STX: begin
            line_byte  = STX_CODE;
            next_phase = PH_LEN;
         end
         PH_LEN: begin
            line_byte  = cmd.len_byte;
            next_phase = (cmd.len_byte == DLE_CODE) ? PH_LEN_DUP : PH_DATA;
         end
         PH_LEN_DUP: begin
            line_byte  = DLE_CODE;
            next_phase = PH_DATA;
         end
         PH_DATA: begin
            line_byte = cmd.data;
            if (cmd.data == DLE_CODE) begin
               next_phase = PH_DATA_DUP;
            end else if (cmd.last) begin
               next_phase = PH_SUM;
            end else begin
               done = 1'b1;
            end
         end
         PH_DATA_DUP: begin
            line_byte = DLE_CODE;
            if (cmd.last) begin
               next_phase = PH_SUM;
            end else begin
               done = 1'b1;
            end
         end
         PH_SUM: begin
            line_byte  = cmd.csum;
            next_phase = (cmd.csum == DLE_CODE) ? PH_SUM_DUP : PH_TRL_DLE;
         end
         PH_SUM_DUP: begin
            line_byte  = DLE_CODE;
            next_phase = PH_TRL_DLE;
         end
         PH_TRL_DLE: begin
            line_byte  = DLE_CODE;
            next_phase = PH_TRL_ETX;
         end
         PH_TRL_ETX: begin
            line_byte = ETX_CODE;
            done      = 1'b1;
         end
         default: begin
            line_byte = DLE_CODE;
            done      = 1'b1;
         end
      endcase
   end

   // sequencer and output valid
   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         busy_in      = !done;
         phase_in     = next_phase;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         phase_ff     <= PH_DATA;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         frame_byte_ff <= line_byte;
         run_last_ff   <= done;
         frame_end_ff  <= (cur_phase == PH_TRL_ETX);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.frame_byte = frame_byte_ff;
   assign rsp_ch.run_last   = run_last_ff;
   assign rsp_ch.frame_end  = frame_end_ff;

   // head request stays queued while it is being expanded
   a_busy_has_cmd: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cmd_valid)
      else $error("sequencer busy with no queued request");

   // closing byte always ends the run of its request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_end_ff |-> run_last_ff)
      else $error("frame end without run last");

   // a partly expanded request keeps the sequencer busy
   a_partial_busy: assert property (@(posedge clock) disable iff (reset)
      load && !done |=> busy_ff)
      else $error("sequencer dropped a partly sent request");

   // closing byte is always ETX
   a_end_is_etx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_end_ff |-> frame_byte_ff == ETX_CODE)
      else $error("frame end on a byte other than ETX");

endmodule

`default_nettype wire
